FILE: hw/rtl/positional_array_list_macros.svh
// ----------------------------------------------------------------------------
// positional array list assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// same-cycle implication
`define PAL_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("positional array list assertion failed");

// next-cycle implication
`define PAL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("positional array list assertion failed");

`endif

FILE: hw/rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// types and fixed constants of the positional array list
// ----------------------------------------------------------------------------
package pal_pkg;

	localparam int POS_W  = 7;
	localparam int DATA_W = 32;
	localparam int CMP_W  = POS_W + 1;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_READ   = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_BADPOS = 2'd1,
		STATUS_FULL   = 2'd2,
		STATUS_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		func_t                     func;
		logic [POS_W-1:0]          position;
		logic signed [DATA_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  element;
		logic                      last;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic read_start;
		logic read_next;
	} cmd_t;

	typedef struct packed {
		logic in_op_valid;
		logic read_nonempty;
		logic out_free;
		logic rd_last;
	} stat_t;

endpackage

FILE: hw/rtl/pal_ctrl.sv
// ----------------------------------------------------------------------------
// pal_ctrl
// sequencer: capture an operation, execute it, stream entries on read-all
// ----------------------------------------------------------------------------
module pal_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pal_pkg::stat_t  stat,
	output pal_pkg::cmd_t   cmd
);

	pal_pkg::state_t state_q;
	pal_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pal_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pal_pkg::S_IDLE: begin
				if (in_valid && stat.in_op_valid) begin
					state_d = pal_pkg::S_EXEC;
				end
			end
			pal_pkg::S_EXEC: begin
				if (stat.read_nonempty) begin
					state_d = pal_pkg::S_READ;
				end else if (stat.out_free) begin
					state_d = pal_pkg::S_IDLE;
				end
			end
			pal_pkg::S_READ: begin
				if (stat.out_free && stat.rd_last) begin
					state_d = pal_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pal_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pal_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid && stat.in_op_valid;
			end
			pal_pkg::S_EXEC: begin
				if (stat.read_nonempty) begin
					cmd.read_start = 1'b1;
				end else if (stat.out_free) begin
					cmd.exec = 1'b1;
				end
			end
			pal_pkg::S_READ: begin
				cmd.read_next = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: hw/rtl/pal_datapath.sv
// ----------------------------------------------------------------------------
// pal_datapath
// shifting chain of entry cells, length count, operation and output registers
// ----------------------------------------------------------------------------
`include "positional_array_list_macros.svh"

module pal_datapath #(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pal_pkg::in_item_t   in_item,
	input  pal_pkg::cmd_t       cmd,
	output pal_pkg::stat_t      stat,
	output logic                out_valid,
	input  logic                out_ready,
	output pal_pkg::out_item_t  out_item
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LEN_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = pal_pkg::CMP_W;
	localparam int DW    = pal_pkg::DATA_W;

	logic signed [DW-1:0]       cell_q [CAPACITY];
	logic signed [DW-1:0]       cell_d [CAPACITY];
	logic signed [DW-1:0]       up_nb  [CAPACITY];
	logic signed [DW-1:0]       dn_nb  [CAPACITY];

	pal_pkg::func_t             func_q;
	logic [pal_pkg::POS_W-1:0]  pos_q;
	logic signed [DW-1:0]       val_q;
	logic [LEN_W-1:0]           len_q;
	logic [LEN_W-1:0]           rd_idx_q;
	pal_pkg::out_item_t         out_q;
	logic                       out_valid_q;

	logic [CMP_W-1:0]           pos_x;
	logic [CMP_W-1:0]           len_x;
	logic [CMP_W-1:0]           pos_m1;
	logic                       ins_bad;
	logic                       full;
	logic                       del_bad;
	logic                       do_ins;
	logic                       do_del;
	logic [IDX_W-1:0]           rd_addr;
	logic signed [DW-1:0]       rd_data;
	logic                       rd_last;
	logic                       load;
	pal_pkg::status_t           res_status;
	logic signed [DW-1:0]       res_element;

	// position checks
	assign pos_x   = CMP_W'(pos_q);
	assign len_x   = CMP_W'(len_q);
	assign pos_m1  = pos_x - CMP_W'(1);
	assign ins_bad = (pos_x == '0) || (pos_x > len_x + CMP_W'(1));
	assign full    = (len_q == LEN_W'(CAPACITY));
	assign del_bad = (pos_x == '0) || (pos_x > len_x);
	assign do_ins  = cmd.exec && (func_q == pal_pkg::FUNC_INSERT) && !ins_bad && !full;
	assign do_del  = cmd.exec && (func_q == pal_pkg::FUNC_DELETE) && !del_bad;

	// neighbor taps of each cell
	for (genvar k = 0; k < CAPACITY; k++) begin : g_nb
		if (k == 0) begin : g_first
			assign up_nb[k] = val_q;
		end else begin : g_up
			assign up_nb[k] = cell_q[k-1];
		end
		if (k == CAPACITY - 1) begin : g_end
			assign dn_nb[k] = cell_q[k];
		end else begin : g_dn
			assign dn_nb[k] = cell_q[k+1];
		end
	end

	always_comb begin
		for (int k = 0; k < CAPACITY; k++) begin
			cell_d[k] = cell_q[k];
			if (do_ins) begin
				if (CMP_W'(k) == pos_m1) begin
					cell_d[k] = val_q;
				end else if (CMP_W'(k) > pos_m1) begin
					cell_d[k] = up_nb[k];
				end
			end else if (do_del && (CMP_W'(k) >= pos_m1)) begin
				cell_d[k] = dn_nb[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_ins || do_del) begin
			cell_q <= cell_d;
		end
	end

	// single read port: deleted entry or streamed entry
	assign rd_addr = cmd.read_next ? rd_idx_q[IDX_W-1:0] : pos_m1[IDX_W-1:0];
	assign rd_data = cell_q[rd_addr];
	assign rd_last = (rd_idx_q == len_q - LEN_W'(1));

	always_comb begin
		res_status  = pal_pkg::STATUS_OK;
		res_element = '0;
		case (func_q)
			pal_pkg::FUNC_INSERT: begin
				if (ins_bad) begin
					res_status = pal_pkg::STATUS_BADPOS;
				end else if (full) begin
					res_status = pal_pkg::STATUS_FULL;
				end
			end
			pal_pkg::FUNC_DELETE: begin
				if (del_bad) begin
					res_status = pal_pkg::STATUS_BADPOS;
				end else begin
					res_element = rd_data;
				end
			end
			default: begin
				res_status = pal_pkg::STATUS_EMPTY;
			end
		endcase
	end

	// operation capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= in_item.func;
			pos_q  <= in_item.position;
			val_q  <= in_item.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			if (do_ins) begin
				len_q <= len_q + LEN_W'(1);
			end else if (do_del) begin
				len_q <= len_q - LEN_W'(1);
			end
			if (cmd.read_start) begin
				rd_idx_q <= '0;
			end else if (cmd.read_next) begin
				rd_idx_q <= rd_idx_q + LEN_W'(1);
			end
		end
	end

	// output register
	assign load = cmd.exec || cmd.read_next;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_q.status  <= res_status;
			out_q.element <= res_element;
			out_q.last    <= 1'b1;
		end else if (cmd.read_next) begin
			out_q.status  <= pal_pkg::STATUS_OK;
			out_q.element <= rd_data;
			out_q.last    <= rd_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign stat.in_op_valid   = (in_item.func == pal_pkg::FUNC_INSERT) ||
		(in_item.func == pal_pkg::FUNC_DELETE) || (in_item.func == pal_pkg::FUNC_READ);
	assign stat.read_nonempty = (func_q == pal_pkg::FUNC_READ) && (len_q != '0);
	assign stat.out_free      = !out_valid_q || out_ready;
	assign stat.rd_last       = rd_last;

	`PAL_ASSERT_IMPL(a_len_in_range, 1'b1, len_q <= LEN_W'(CAPACITY))
	`PAL_ASSERT_IMPL(a_load_into_free_slot, load, !out_valid_q || out_ready)
	`PAL_ASSERT_IMPL(a_stream_within_length, cmd.read_next, rd_idx_q < len_q)
	`PAL_ASSERT_NEXT(a_insert_grows, do_ins, len_q == $past(len_q) + LEN_W'(1))

endmodule

FILE: hw/rtl/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list
// ordered list of signed 32-bit words with positional insert and delete
// ----------------------------------------------------------------------------
// The block keeps an ordered list of up to CAPACITY signed words in a chain
// of register cells plus a length count, and takes one operation per
// transfer on the input channel: insert at a 1-based position (1 to
// length+1), delete at a 1-based position (1 to length, the removed word is
// returned), or read-all (every entry in order, last set on the final one,
// a single "empty" result if the list holds nothing). A bad position
// answers status 1 and a valid insert into a full list answers status 2;
// the list is then left as it was. Items are handled one at a time by a
// small sequencer: an item is accepted while idle and then executed;
// read-all streams the entries (one output transfer per entry through the
// single cell read port), and an item with the unused operation code is
// dropped in its accept cycle. Whole-chain shifts for insert and delete
// happen at once, when the item executes. Results sit in an output
// register, so a stalled output only holds the block when it has a new
// result to hand over. The stored words are not cleared at reset; only
// entries below the length are ever read.
// ----------------------------------------------------------------------------
module positional_array_list #(
	parameter int CAPACITY = 64   // list capacity, 1 to 64
) (
	input  logic                clk,
	input  logic                arst_n,
	// operation channel
	input  logic                in_valid,
	output logic                in_ready,
	input  pal_pkg::in_item_t   in_item,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output pal_pkg::out_item_t  out_item
);

	// commands from the sequencer, status back from the datapath
	pal_pkg::cmd_t  cmd;
	pal_pkg::stat_t stat;

	// sequencer: idle -> execute -> (stream entries on read-all)
	pal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// cell chain, length count, captured operation and output register
	pal_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
